// File: design/sh64_pkg.sv
// shared constants and helpers for the streaming 64-bit word-fold hash
package sh64_pkg;

    localparam int LEN_W      = 32;
    localparam int WORD_IDX_W = 29;

    localparam logic [3:0] NB_FULL = 4'd8;

    localparam logic [63:0] K0 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] K1 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] K2 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] K3 = 64'h165667B19E3779F9;
    localparam logic [63:0] K4 = 64'h27D4EB2F165667C5;

    localparam logic [5:0] ROT_LANE0 = 6'd27;
    localparam logic [5:0] ROT_LANE1 = 6'd31;
    localparam logic [5:0] ROT_LANE2 = 6'd23;
    localparam logic [5:0] ROT_LANE3 = 6'd29;
    localparam logic [5:0] ROT_BYTE  = 6'd11;

    // rotate left, called with constant amounts only
    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        logic [6:0] rr;
        begin
            rr = 7'd64 - {1'b0, r};
            rotl64 = (x << r) | (x >> rr);
        end
    endfunction

    // multiply constant of each lane
    function automatic logic [63:0] lane_const(input logic [1:0] lane);
        begin
            case (lane)
                2'd1:    lane_const = K2;
                2'd2:    lane_const = K3;
                2'd3:    lane_const = K4;
                default: lane_const = K1;
            endcase
        end
    endfunction

endpackage

// File: design/streaming_hash64_word_fold.sv
// streaming 64-bit word-fold hash with avalanche finalizer, single shared multiplier
//
// One message streams in as little-endian 64-bit words, one word per input
// transfer, with the final word flagged by last. The first transfer of a
// message starts the hash from the seed register xor (message_length * K0);
// full words are folded by their lane rule when their 32-byte chunk lies
// inside the message, else by lane 0's rule, and a partial word is folded a
// byte at a time. The transfer flagged last produces one digest on the
// output channel; no other transfer produces a result. An empty message is
// a single transfer with valid_bytes zero and last set. valid_bytes above 8
// counts as 8. All 64x64 products (mod 2^64) go through one 32x32 multiplier
// as three partial products, and the block is not ready while an item is
// being worked on. A full word takes one product and a partial word one per
// valid byte; the first transfer of a message adds the start product, and a
// last transfer adds the two finalizer products. The digest sits in an output
// register, so a new message may start while the previous digest waits to be
// taken; the finalizer only stalls if a digest is still pending when the next
// is ready.
// seed is written through cfg_wr_en / cfg_wr_data and must only be changed
// between messages.
module streaming_hash64_word_fold (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [63:0]              cfg_wr_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [63:0]              data_word,
    input  logic [3:0]               valid_bytes,
    input  logic                     last,
    input  logic [sh64_pkg::LEN_W-1:0] message_length,
    // output channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [63:0]              digest
);
    import sh64_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BODY,
        S_MUL,
        S_FOLD,
        S_END
    } state_t;

    typedef enum logic [2:0] {
        OP_START,
        OP_WORD,
        OP_BYTE,
        OP_FIN1,
        OP_FIN2
    } op_t;

    state_t                state_reg;
    op_t                   op_reg;
    logic [63:0]           seed_reg;
    logic [63:0]           hash_reg;
    logic [WORD_IDX_W-1:0] word_idx_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  in_msg_reg;
    logic [63:0]           word_reg;
    logic [3:0]            nb_reg;
    logic                  last_reg;
    logic [2:0]            byte_k_reg;
    logic [1:0]            lane_reg;
    // shared multiplier operands and accumulator
    logic [63:0]           op_a_reg;
    logic [63:0]           k_reg;
    logic [1:0]            mul_step_reg;
    logic [63:0]           prod_reg;
    logic [63:0]           acc_reg;
    logic                  out_valid_reg;
    logic [63:0]           digest_reg;

    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           mul_p;
    logic [WORD_IDX_W-2:0] chunk_num;
    logic [LEN_W:0]        chunk_end;
    logic [1:0]            lane;
    logic [63:0]           fold_val;
    logic [7:0]            cur_byte;
    logic                  in_xfer;
    logic                  digest_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;

    // finished digest moves into the output register once it is free
    assign digest_load = (state_reg == S_FOLD) && (op_reg == OP_FIN2)
                         && (!out_valid_reg || out_ready);

    // partial-product select: lo*lo, lo*hi, hi*lo (hi*hi drops out mod 2^64)
    always_comb
    begin
        mul_a = (mul_step_reg == 2'd2) ? op_a_reg[63:32] : op_a_reg[31:0];
        mul_b = (mul_step_reg == 2'd1) ? k_reg[63:32] : k_reg[31:0];
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // lane choice: full chunk when (word_idx/4 + 1) * 32 <= length
    always_comb
    begin
        chunk_num = {1'b0, word_idx_reg[WORD_IDX_W-1:2]} + 28'd1;
        chunk_end = {chunk_num, 5'b0};
        lane      = (chunk_end <= {1'b0, len_reg}) ? word_idx_reg[1:0] : 2'd0;
        cur_byte  = word_reg[{byte_k_reg, 3'b000} +: 8];
    end

    // combine the finished product into the running hash
    always_comb
    begin
        case (op_reg)
            OP_WORD:
            begin
                case (lane_reg)
                    2'd1:    fold_val = rotl64(hash_reg + acc_reg, ROT_LANE1);
                    2'd2:    fold_val = rotl64(hash_reg ^ acc_reg, ROT_LANE2);
                    2'd3:    fold_val = rotl64(hash_reg + acc_reg, ROT_LANE3);
                    default: fold_val = rotl64(hash_reg ^ acc_reg, ROT_LANE0);
                endcase
            end
            OP_BYTE: fold_val = rotl64(hash_reg ^ acc_reg, ROT_BYTE);
            default: fold_val = hash_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_START;
            seed_reg      <= '0;
            hash_reg      <= '0;
            word_idx_reg  <= '0;
            len_reg       <= '0;
            in_msg_reg    <= 1'b0;
            word_reg      <= '0;
            nb_reg        <= '0;
            last_reg      <= 1'b0;
            byte_k_reg    <= '0;
            lane_reg      <= '0;
            op_a_reg      <= '0;
            k_reg         <= '0;
            mul_step_reg  <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            digest_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
            if (digest_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        word_reg   <= data_word;
                        nb_reg     <= (valid_bytes > NB_FULL) ? NB_FULL : valid_bytes;
                        last_reg   <= last;
                        byte_k_reg <= '0;
                        if (!in_msg_reg)
                        begin
                            // first transfer of a message: start value product
                            len_reg      <= message_length;
                            word_idx_reg <= '0;
                            in_msg_reg   <= 1'b1;
                            op_a_reg     <= 64'(message_length);
                            k_reg        <= K0;
                            op_reg       <= OP_START;
                            mul_step_reg <= '0;
                            state_reg    <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_BODY;
                        end
                    end
                end

                S_BODY:
                begin
                    mul_step_reg <= '0;
                    if (nb_reg == NB_FULL)
                    begin
                        op_a_reg  <= word_reg;
                        k_reg     <= lane_const(lane);
                        lane_reg  <= lane;
                        op_reg    <= OP_WORD;
                        state_reg <= S_MUL;
                    end
                    else if ({1'b0, byte_k_reg} < nb_reg)
                    begin
                        op_a_reg  <= 64'(cur_byte);
                        k_reg     <= K4;
                        op_reg    <= OP_BYTE;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_END;
                    end
                end

                S_MUL:
                begin
                    prod_reg     <= mul_p;
                    mul_step_reg <= mul_step_reg + 2'd1;
                    case (mul_step_reg)
                        2'd1:
                        begin
                            acc_reg <= prod_reg;
                        end
                        2'd2:
                        begin
                            acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                        end
                        2'd3:
                        begin
                            acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                            state_reg      <= S_FOLD;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                S_FOLD:
                begin
                    case (op_reg)
                        OP_START:
                        begin
                            hash_reg  <= seed_reg ^ acc_reg;
                            state_reg <= S_BODY;
                        end
                        OP_WORD:
                        begin
                            hash_reg  <= fold_val;
                            state_reg <= S_END;
                        end
                        OP_BYTE:
                        begin
                            hash_reg   <= fold_val;
                            byte_k_reg <= byte_k_reg + 3'd1;
                            state_reg  <= S_BODY;
                        end
                        OP_FIN1:
                        begin
                            op_a_reg     <= acc_reg ^ (acc_reg >> 29);
                            k_reg        <= K2;
                            op_reg       <= OP_FIN2;
                            mul_step_reg <= '0;
                            state_reg    <= S_MUL;
                        end
                        OP_FIN2:
                        begin
                            // hold until the output register is free
                            if (digest_load)
                            begin
                                digest_reg <= acc_reg ^ (acc_reg >> 32);
                                state_reg  <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_END:
                begin
                    word_idx_reg <= word_idx_reg + 29'd1;
                    if (last_reg)
                    begin
                        in_msg_reg   <= 1'b0;
                        op_a_reg     <= hash_reg ^ (hash_reg >> 33);
                        k_reg        <= K1;
                        op_reg       <= OP_FIN1;
                        mul_step_reg <= '0;
                        state_reg    <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // first transfer of a message always launches the start product
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !in_msg_reg) |=> (state_reg == S_MUL && op_reg == OP_START))
        else $error("start product not launched on first transfer");

    // the last partial-product step always hands over to the fold
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && mul_step_reg == 2'd3) |=> (state_reg == S_FOLD))
        else $error("multiply sequence did not finish after three partial products");

    // byte counter never runs past the number of valid bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BODY && nb_reg != NB_FULL) |-> ({1'b0, byte_k_reg} <= nb_reg))
        else $error("byte index beyond valid bytes");

    // a pending digest is never overwritten by the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FOLD && op_reg == OP_FIN2 && out_valid_reg && !out_ready)
            |=> (state_reg == S_FOLD && $stable(digest_reg)))
        else $error("digest overwritten while still pending");

endmodule
